// ===== rtl/quadratic_root_solver_top_macros.svh =====
// ---------------------------------------------------------------------------
// quadratic_root_solver_top_macros
// Assertion macros used by the solver top module.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define QRS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qrs_pkg.sv =====
// ---------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ---------------------------------------------------------------------------
package qrs_pkg;

  localparam int TOL_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-3:0] REG_TOL = '0;

  typedef enum logic [1:0] {
    KIND_ANY_X   = 2'd0,
    KIND_NO_ROOT = 2'd1,
    KIND_SINGLE  = 2'd2,
    KIND_TWO     = 2'd3
  } root_kind_e;

endpackage

// ===== rtl/qrs_stream_if.sv =====
// ---------------------------------------------------------------------------
// qrs_coef_if / qrs_root_if
// Valid/ready channels for coefficient sets and root results.
// ---------------------------------------------------------------------------
interface qrs_coef_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  qrs_pkg::root_kind_e         root_kind;
  logic signed [WORD_BITS-1:0] root_first;
  logic signed [WORD_BITS-1:0] root_second;
  logic                        saturated;

  modport source (output valid, output root_kind, output root_first, output root_second,
                  output saturated, input ready);
  modport sink   (input valid, input root_kind, input root_first, input root_second,
                  input saturated, output ready);
endinterface

// ===== rtl/qrs_isqrt.sv =====
// ---------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ---------------------------------------------------------------------------
module qrs_isqrt #(
  parameter int ROOT_W = 33
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int RW    = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [RW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RW+1:0]     sh;
    logic [RW+1:0]     trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
        if (sh >= trial) begin
          rem_q[k]  <= RW'(sh - trial);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= RW'(sh);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ===== rtl/qrs_div_pipe.sv =====
// ---------------------------------------------------------------------------
// qrs_div_pipe
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module qrs_div_pipe #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o
);

  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   sh;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign sh = {rem_in, num_in[NUM_W-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NUM_W-2:0], 1'b0};
        den_q[k] <= den_in;
        if (sh >= {1'b0, den_in}) begin
          rem_q[k] <= DEN_W'(sh - {1'b0, den_in});
          quo_q[k] <= {quo_in[NUM_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= DEN_W'(sh);
          quo_q[k] <= {quo_in[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];
  assign rem_o = rem_q[NUM_W-1];
  assign den_o = den_q[NUM_W-1];

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// ---------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2+b*x+c=0 for signed fixed-point coefficients (Q16.16 by default).
// ---------------------------------------------------------------------------
// Takes one coefficient set per cycle, while coef_i.ready is high, and returns
// one result transaction per set, in order. Each set passes through registers
// for magnitudes, products and discriminant, the square root (one root bit per
// stage), a numerator register, the two dividers (one quotient bit per stage),
// a rounding and clamping register and the output buffer. A two-entry output
// buffer lets the pipeline keep moving while a result waits; it stalls only
// when both entries are full.
// zero_tolerance sits at APB address 0.
module quadratic_root_solver_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  qrs_coef_if.sink                         coef_i,
  qrs_root_if.source                       root_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qrs_pkg::PADDR_W-1:0]      paddr,
  input  logic [qrs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qrs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  `include "quadratic_root_solver_top_macros.svh"

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int DW    = 2 * W + 3;
  localparam int SQ_W  = W + 1;
  localparam int NUM_W = W + F + 1;
  localparam int DEN_W = W + 1;
  localparam int VW    = W + 3;

  typedef struct packed {
    qrs_pkg::root_kind_e kind;
    logic                lin;
    logic                an;
    logic                bn;
    logic                cn;
    logic [W-1:0]        am;
    logic [W-1:0]        bm;
    logic [W-1:0]        cm;
  } sq_side_t;

  typedef struct packed {
    qrs_pkg::root_kind_e kind;
    logic                neg1;
    logic                neg2;
  } dv_side_t;

  typedef struct packed {
    qrs_pkg::root_kind_e kind;
    logic [W-1:0]        first;
    logic [W-1:0]        second;
    logic                sat;
  } result_t;

  function automatic logic [W:0] round_sat(logic neg, logic [NUM_W-1:0] quo,
                                           logic [DEN_W-1:0] rem, logic [DEN_W-1:0] den);
    logic [NUM_W:0] q2;
    logic [NUM_W:0] lim;
    logic           up;
    logic           sat;
    logic [W-1:0]   mag;
    up  = {rem, 1'b0} >= {1'b0, den};
    q2  = {1'b0, quo} + (NUM_W+1)'(up);
    lim = ((NUM_W+1)'(1) << (W - 1)) - (NUM_W+1)'(!neg);
    sat = q2 > lim;
    mag = sat ? lim[W-1:0] : q2[W-1:0];
    return {sat, neg ? W'(0) - mag : mag};
  endfunction

  // Configuration
  logic [qrs_pkg::TOL_W-1:0] tol_q;
  logic                      reg_hit;

  assign reg_hit = paddr[qrs_pkg::PADDR_W-1:2] == qrs_pkg::REG_TOL;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? qrs_pkg::APB_DATA_W'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tol_q <= pwdata[qrs_pkg::TOL_W-1:0];
    end
  end

  // Flow control
  logic    adv;
  logic    push;
  logic    pop;
  logic [1:0] cnt_q, cnt_d;
  result_t slot0_q, slot0_d, slot1_q, slot1_d, res;

  assign adv          = (cnt_q != 2'd2) || root_o.ready;
  assign coef_i.ready = adv;

  // Stage 1: sign and magnitude
  logic         v1_q;
  logic         an1_q, bn1_q, cn1_q;
  logic [W-1:0] am1_q, bm1_q, cm1_q;
  logic [W-1:0] a_raw, b_raw, c_raw;

  assign a_raw = coef_i.coef_a;
  assign b_raw = coef_i.coef_b;
  assign c_raw = coef_i.coef_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      an1_q <= a_raw[W-1];
      bn1_q <= b_raw[W-1];
      cn1_q <= c_raw[W-1];
      am1_q <= a_raw[W-1] ? W'(0) - a_raw : a_raw;
      bm1_q <= b_raw[W-1] ? W'(0) - b_raw : b_raw;
      cm1_q <= c_raw[W-1] ? W'(0) - c_raw : c_raw;
    end
  end

  // Stage 2: products and tolerance checks
  logic           v2_q;
  logic           an2_q, bn2_q, cn2_q, lin2_q, bz2_q, cz2_q;
  logic [W-1:0]   am2_q, bm2_q, cm2_q;
  logic [2*W-1:0] bb2_q, ac2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      an2_q  <= an1_q;
      bn2_q  <= bn1_q;
      cn2_q  <= cn1_q;
      am2_q  <= am1_q;
      bm2_q  <= bm1_q;
      cm2_q  <= cm1_q;
      lin2_q <= am1_q <= W'(tol_q);
      bz2_q  <= bm1_q <= W'(tol_q);
      cz2_q  <= cm1_q <= W'(tol_q);
      bb2_q  <= (2*W)'(bm1_q) * (2*W)'(bm1_q);
      ac2_q  <= (2*W)'(am1_q) * (2*W)'(cm1_q);
    end
  end

  // Stage 3: discriminant
  logic          v3_q;
  logic          an3_q, bn3_q, cn3_q, lin3_q, bz3_q, cz3_q, dneg3_q;
  logic [W-1:0]  am3_q, bm3_q, cm3_q;
  logic [DW-1:0] d3_q;
  logic [DW-1:0] d_d;

  assign d_d = (an2_q ^ cn2_q) ? DW'(bb2_q) + DW'({ac2_q, 2'b00})
                               : DW'(bb2_q) - DW'({ac2_q, 2'b00});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      an3_q   <= an2_q;
      bn3_q   <= bn2_q;
      cn3_q   <= cn2_q;
      am3_q   <= am2_q;
      bm3_q   <= bm2_q;
      cm3_q   <= cm2_q;
      lin3_q  <= lin2_q;
      bz3_q   <= bz2_q;
      cz3_q   <= cz2_q;
      d3_q    <= d_d;
      dneg3_q <= !(an2_q ^ cn2_q) && d_d[DW-1];
    end
  end

  // Square root with side delay
  qrs_pkg::root_kind_e kind3;
  sq_side_t            sq_side_d;
  sq_side_t            sq_side_q [SQ_W];
  logic [SQ_W-1:0]     sq_vld_q;
  logic [SQ_W-1:0]     s_root;

  always_comb begin
    if (lin3_q) begin
      kind3 = bz3_q ? (cz3_q ? qrs_pkg::KIND_ANY_X : qrs_pkg::KIND_NO_ROOT)
                    : qrs_pkg::KIND_SINGLE;
    end else if (dneg3_q) begin
      kind3 = qrs_pkg::KIND_NO_ROOT;
    end else if (d3_q == '0) begin
      kind3 = qrs_pkg::KIND_SINGLE;
    end else begin
      kind3 = qrs_pkg::KIND_TWO;
    end
  end

  assign sq_side_d = '{kind: kind3, lin: lin3_q, an: an3_q, bn: bn3_q, cn: cn3_q,
                       am: am3_q, bm: bm3_q, cm: cm3_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_side_q[0] <= sq_side_d;
      for (int k = 1; k < SQ_W; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  qrs_isqrt #(
    .ROOT_W (SQ_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (d3_q[2*SQ_W-1:0]),
    .root_o (s_root)
  );

  // Numerators and denominator
  sq_side_t         sq_out;
  logic             vn_q;
  logic [NUM_W-1:0] num1_q, num2_q, num1_d, num2_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             neg1_d, neg2_d;
  dv_side_t         dv_side_d;
  logic [VW-1:0]    negb, val1, val2, mag1, mag2;

  assign sq_out = sq_side_q[SQ_W-1];
  assign negb   = sq_out.bn ? VW'(sq_out.bm) : VW'(0) - VW'(sq_out.bm);
  assign val1   = negb + VW'(s_root);
  assign val2   = negb - VW'(s_root);
  assign mag1   = val1[VW-1] ? VW'(0) - val1 : val1;
  assign mag2   = val2[VW-1] ? VW'(0) - val2 : val2;

  always_comb begin
    num2_d = '0;
    neg2_d = 1'b0;
    if (sq_out.lin) begin
      num1_d = NUM_W'(sq_out.cm) << F;
      den_d  = DEN_W'(sq_out.bm);
      neg1_d = sq_out.cn == sq_out.bn;
    end else begin
      den_d = {sq_out.am, 1'b0};
      if (sq_out.kind == qrs_pkg::KIND_TWO) begin
        num1_d = NUM_W'(mag1) << F;
        num2_d = NUM_W'(mag2) << F;
        neg1_d = val1[VW-1] != sq_out.an;
        neg2_d = val2[VW-1] != sq_out.an;
      end else begin
        num1_d = NUM_W'(sq_out.bm) << F;
        neg1_d = sq_out.bn == sq_out.an;
      end
    end
  end

  dv_side_t dv_side_n_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num1_q      <= num1_d;
      num2_q      <= num2_d;
      den_q       <= den_d;
      dv_side_n_q <= dv_side_d;
    end
  end

  assign dv_side_d = '{kind: sq_out.kind, neg1: neg1_d, neg2: neg2_d};

  // Dividers with side delay
  dv_side_t         dv_side_q [NUM_W];
  logic [NUM_W-1:0] dv_vld_q;
  logic [NUM_W-1:0] quo1, quo2;
  logic [DEN_W-1:0] rem1, rem2, den1, den2;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= dv_side_n_q;
      for (int k = 1; k < NUM_W; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  qrs_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_first (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num1_q),
    .den_i (den_q),
    .quo_o (quo1),
    .rem_o (rem1),
    .den_o (den1)
  );

  qrs_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_second (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num2_q),
    .den_i (den_q),
    .quo_o (quo2),
    .rem_o (rem2),
    .den_o (den2)
  );

  // Round and clamp
  dv_side_t dv_out;
  logic [W:0] rs1, rs2;
  logic       has1, has2;
  logic       vr_q;
  result_t    res_q, res_d;

  assign dv_out = dv_side_q[NUM_W-1];
  assign rs1    = round_sat(dv_out.neg1, quo1, rem1, den1);
  assign rs2    = round_sat(dv_out.neg2, quo2, rem2, den2);
  assign has2   = dv_out.kind == qrs_pkg::KIND_TWO;
  assign has1   = has2 || dv_out.kind == qrs_pkg::KIND_SINGLE;

  assign res_d = '{kind:   dv_out.kind,
                   first:  has1 ? rs1[W-1:0] : '0,
                   second: has2 ? rs2[W-1:0] : '0,
                   sat:    (has1 && rs1[W]) || (has2 && rs2[W])};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      sq_vld_q <= '0;
      vn_q     <= 1'b0;
      dv_vld_q <= '0;
      vr_q     <= 1'b0;
    end else if (adv) begin
      v1_q     <= coef_i.valid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      sq_vld_q <= {sq_vld_q[SQ_W-2:0], v3_q};
      vn_q     <= sq_vld_q[SQ_W-1];
      dv_vld_q <= {dv_vld_q[NUM_W-2:0], vn_q};
      vr_q     <= dv_vld_q[NUM_W-1];
    end
  end

  // Output buffer
  assign res  = res_q;
  assign push = adv && vr_q;
  assign pop  = root_o.valid && root_o.ready;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
    if (push) begin
      if (cnt_d == 2'd0) begin
        slot0_d = res;
      end else begin
        slot1_d = res;
      end
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign root_o.valid       = cnt_q != 2'd0;
  assign root_o.root_kind   = slot0_q.kind;
  assign root_o.root_first  = slot0_q.first;
  assign root_o.root_second = slot0_q.second;
  assign root_o.saturated   = slot0_q.sat;

  `QRS_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_q != 2'd3, "output buffer count out of range")
  `QRS_ASSERT_IMPLIES(a_no_overflow, push && cnt_q == 2'd2, pop,
                      "result pushed into a full output buffer")
  `QRS_ASSERT_IMPLIES(a_no_root_zero,
                      root_o.valid && (root_o.root_kind == qrs_pkg::KIND_ANY_X ||
                                       root_o.root_kind == qrs_pkg::KIND_NO_ROOT),
                      root_o.root_first == '0 && root_o.root_second == '0 &&
                      !root_o.saturated,
                      "rootless result carries root data")
  `QRS_ASSERT_IMPLIES(a_second_zero,
                      root_o.valid && root_o.root_kind != qrs_pkg::KIND_TWO,
                      root_o.root_second == '0, "second root set without two roots")
  `QRS_ASSERT_NEXT(a_hold_full, cnt_q == 2'd2 && !root_o.ready, cnt_q == 2'd2,
                   "full output buffer drained without a transaction")

endmodule
